// ===== rtl/core/debug_packet_deframer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Debug packet deframer assertion macros
// Shared concurrent assertion forms for the deframer checker.
// ----------------------------------------------------------------------------
`ifndef DEBUG_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define DEBUG_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define DPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/dpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dpd_pkg
// Types, character codes and the hex decoder for the debug packet deframer.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [7:0] CH_INTR  = 8'h03;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_SUM1 = 2'd2,
    PH_SUM2 = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_GOOD    = 3'd2,
    KIND_BADSUM  = 3'd3,
    KIND_INTR    = 3'd4,
    KIND_FRAMING = 3'd5
  } kind_e;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  sum;
    logic [3:0]  hi_nib;
  } dpd_state_t;

  // ASCII hex digit to nibble; anything else reads as zero.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      n = c[3:0] + 4'd9;
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/debug_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// debug_packet_deframer_unit
// Byte-serial receiver for '$' payload '#' hh debug-stream packets.
// ----------------------------------------------------------------------------
// Every accepted byte yields exactly one result beat via the input and result
// registers: kind 0 (nothing), 1 (payload byte), 2 (packet good), 3 (checksum
// mismatch), 4 (interrupt, byte 0x03 between packets) or 5 (framing error,
// stray byte between packets). Throughput is one byte per cycle while the
// output is not stalled; it is set by the update of the framing state (phase,
// 8-bit running sum, first checksum nibble) as a byte moves from the input
// register to the result register. A stall on the output backs up through
// both registers, so up to two beats are held inside when in_stall_o rises.
// Checksum chars that are not hex decode as zero; both letter cases count.
// ----------------------------------------------------------------------------
module debug_packet_deframer_unit import dpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o
);

  // input register
  logic        in_vld_q;
  logic [7:0]  in_byte_q;

  // framing state
  dpd_state_t  st_q, st_d;

  // result register
  logic        out_vld_q;
  kind_e       kind_q, kind_d;
  logic [7:0]  data_q, data_d;

  logic        out_free;   // result register can take a beat this cycle
  logic        adv;        // input register moves on into the result register
  logic        in_acc;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  dpd_step u_step (
    .st_i     (st_q),
    .byte_i   (in_byte_q),
    .st_nxt_o (st_d),
    .kind_o   (kind_d),
    .data_o   (data_d)
  );

  // input register: refilled on accept, drained on advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // framing state only moves when a byte is actually processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, sum: 8'h00, hi_nib: 4'h0};
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q <= kind_d;
      data_q <= data_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = kind_q;
  assign data_byte_o = data_q;

endmodule

// ===== rtl/core/dpd_step.sv =====
// ----------------------------------------------------------------------------
// dpd_step
// Per-byte framing logic: next deframer state and the result for one beat.
// ----------------------------------------------------------------------------
module dpd_step import dpd_pkg::*; (
  input  dpd_state_t  st_i,
  input  logic [7:0]  byte_i,
  output dpd_state_t  st_nxt_o,
  output kind_e       kind_o,
  output logic [7:0]  data_o
);

  logic [7:0] rx_sum;

  assign rx_sum = {st_i.hi_nib, hex_nibble(byte_i)};

  always_comb begin
    st_nxt_o = st_i;
    kind_o   = KIND_NONE;
    data_o   = 8'h00;
    case (st_i.phase)
      PH_IDLE: begin
        if (byte_i == CH_ACK) begin
          kind_o = KIND_NONE;
        end else if (byte_i == CH_INTR) begin
          kind_o = KIND_INTR;
        end else if (byte_i == CH_START) begin
          st_nxt_o.sum   = 8'h00;
          st_nxt_o.phase = PH_BODY;
        end else begin
          kind_o = KIND_FRAMING;
        end
      end
      PH_BODY: begin
        if (byte_i == CH_END) begin
          st_nxt_o.phase = PH_SUM1;
        end else begin
          st_nxt_o.sum = st_i.sum + byte_i;
          kind_o       = KIND_PAYLOAD;
          data_o       = byte_i;
        end
      end
      PH_SUM1: begin
        st_nxt_o.hi_nib = hex_nibble(byte_i);
        st_nxt_o.phase  = PH_SUM2;
      end
      PH_SUM2: begin
        kind_o         = (rx_sum == st_i.sum) ? KIND_GOOD : KIND_BADSUM;
        data_o         = st_i.sum;
        st_nxt_o.phase = PH_IDLE;
      end
      default: begin
        st_nxt_o.phase = PH_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/dpd_checker.sv =====
// ----------------------------------------------------------------------------
// dpd_checker
// Port-level checks for the debug packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "debug_packet_deframer_unit_assert.svh"

module dpd_checker import dpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_o,
  input  logic [7:0]  data_byte_o
);

  logic in_acc;
  logic out_held;
  logic kind_zero_data;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign kind_zero_data = (kind_o == KIND_NONE) || (kind_o == KIND_INTR) ||
                          (kind_o == KIND_FRAMING);

  // held result beat stays put
  `DPD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable({kind_o, data_byte_o}))

  // input only backs up behind a blocked full output
  `DPD_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // results carry a defined kind, and data only where the kind has some
  `DPD_ASSERT_IMP(a_kind_range, clk_i, rst_ni, out_valid_o, kind_o <= KIND_FRAMING)
  `DPD_ASSERT_IMP(a_zero_data, clk_i, rst_ni, out_valid_o && kind_zero_data, data_byte_o == 8'h00)

  // an accepted byte is always followed by a valid beat on the result port
  `DPD_ASSERT_NXT(a_byte_flows, clk_i, rst_ni, in_acc, ##1 out_valid_o)

endmodule

bind debug_packet_deframer_unit dpd_checker u_dpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .data_byte_o (data_byte_o)
);
